// ----- rtl/bswp_pkg.sv -----
// Package for the bounded stack with palindrome check.
// Holds field widths, command and status codes, and the result record.
// No dependencies; every other file of the block but bswp_ram imports it.
package bswp_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POP_W   = 32;
    localparam int FILL_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CHECK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [POP_W-1:0]  popped_value;
        t_status           status;
        logic              is_palindrome;
        logic [FILL_W-1:0] fill_count;
    } t_result;

endpackage

// ----- rtl/bswp_in_if.sv -----
// Command channel of the bounded stack: valid/ready plus command payload.
// Depends on bswp_pkg for the field widths.
interface bswp_in_if import bswp_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);

endinterface

// ----- rtl/bswp_out_if.sv -----
// Result channel of the bounded stack: valid/ready plus result payload.
// Depends on bswp_pkg for the field widths.
interface bswp_out_if import bswp_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [POP_W-1:0] popped_value;
    logic [1:0]              status;
    logic                    is_palindrome;
    logic [FILL_W-1:0]       fill_count;

    modport source (output valid, output popped_value, output status,
                    output is_palindrome, output fill_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input is_palindrome, input fill_count, output ready);

endinterface

// ----- rtl/bswp_ram.sv -----
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing; contents are not reset.
module bswp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- rtl/bounded_stack_with_palindrome.sv -----
// Bounded LIFO stack of signed words with a palindrome check of its contents.
// Depends on bswp_pkg, bswp_in_if, bswp_out_if and bswp_ram.
//
// Usage: each transaction on i_cmd carries a command (push, pop or check) and
// a push value. Every command yields exactly one transaction on o_res, in
// order, carrying the popped word, a status code, the palindrome flag and the
// number of entries held afterwards. A push into a full stack is dropped with
// overflow status; a pop from an empty stack reports underflow and a zero word.
// Flow: a push (or an unused code) is answered through the output register
// after acceptance, and pushes can follow each other every cycle while the
// receiver keeps taking results. A pop reads the top entry through the
// registered read port of the entry memory before its result is formed. A
// check uses the memory's two read ports to fetch one mirrored pair per cycle,
// and each pair is compared in the cycle after its read. Checks on fewer than
// two entries finish like a push. The result sits in an output register, so
// a new command is taken while the previous result waits. If the receiver
// stalls and a second result is ready, it is parked and i_cmd drops ready until the output register frees up.
// Reset clears the entry count and the handshake state; memory contents are
// left alone, since only entries below the count are ever read.
module bounded_stack_with_palindrome import bswp_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bswp_in_if.sink     i_cmd,
    bswp_out_if.source  o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POP   = 4'b0010,
        S_CHECK = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_lo, n_lo;
    logic [AW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_left, n_left;
    logic            r_same, n_same;
    t_result         r_hold, n_hold;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [WORD_BITS-1:0] ram_rdata_a;
    logic [WORD_BITS-1:0] ram_rdata_b;

    logic    accept;
    logic    out_free;
    logic    full;
    logic    empty;
    logic    pair_eq;
    logic    res_valid;
    t_result res;

    bswp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign full        = (r_count == CW'(STACK_DEPTH));
    assign empty       = (r_count == '0);
    assign pair_eq     = (ram_rdata_a == ram_rdata_b);

    // Only a push writes memory, and it does so in its acceptance cycle. Any
    // read of that entry comes from a later command, so no read can overlap
    // the write of the same entry.
    assign ram_waddr = r_count[AW-1:0];
    assign ram_wdata = WORD_BITS'(i_cmd.push_value);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_left      = r_left;
        n_same      = r_same;
        n_hold      = r_hold;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        ram_we      = 1'b0;
        ram_raddr_a = r_lo;
        ram_raddr_b = r_hi;
        res_valid   = 1'b0;
        res         = '{popped_value: '0, status: ST_OK, is_palindrome: 1'b0,
                        fill_count: FILL_W'(r_count)};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_cmd.command))
                        CMD_PUSH: begin
                            res_valid = 1'b1;
                            if (full) begin
                                res.status = ST_OVERFLOW;
                            end else begin
                                ram_we         = 1'b1;
                                n_count        = r_count + CW'(1);
                                res.fill_count = FILL_W'(r_count + CW'(1));
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                res_valid  = 1'b1;
                                res.status = ST_UNDERFLOW;
                            end else begin
                                n_count     = r_count - CW'(1);
                                ram_raddr_a = AW'(r_count - CW'(1));
                                n_state     = S_POP;
                            end
                        end
                        CMD_CHECK: begin
                            if (r_count < CW'(2)) begin
                                // Empty or single-entry contents are symmetric.
                                res_valid         = 1'b1;
                                res.is_palindrome = 1'b1;
                            end else begin
                                // Fetch the outermost pair now and walk inward.
                                ram_raddr_a = '0;
                                ram_raddr_b = AW'(r_count - CW'(1));
                                n_lo        = AW'(1);
                                n_hi        = AW'(r_count - CW'(2));
                                n_left      = CW'((r_count >> 1) - CW'(1));
                                n_same      = 1'b1;
                                n_state     = S_CHECK;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                // The count was already decremented at acceptance.
                res_valid        = 1'b1;
                res.popped_value = POP_W'($signed(ram_rdata_a));
            end
            S_CHECK: begin
                // Compare the pair fetched last cycle while fetching the next.
                if (r_left != '0) begin
                    n_same      = r_same && pair_eq;
                    ram_raddr_a = r_lo;
                    ram_raddr_b = r_hi;
                    n_lo        = r_lo + AW'(1);
                    n_hi        = r_hi - AW'(1);
                    n_left      = r_left - CW'(1);
                end else begin
                    res_valid         = 1'b1;
                    res.is_palindrome = r_same && pair_eq;
                end
            end
            S_HOLD: begin
                res_valid = 1'b1;
                res       = r_hold;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes to the output register when it is free;
        // otherwise it is parked and new commands wait.
        if (res_valid) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_hold  = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_left <= n_left;
        r_same <= n_same;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.popped_value  = r_out.popped_value;
    assign o_res.status        = r_out.status;
    assign o_res.is_palindrome = r_out.is_palindrome;
    assign o_res.fill_count    = r_out.fill_count;

endmodule
